// ===== sv/sklt_pkg.sv =====
// Shared types and codes for the sorted keyed list table.
// Holds the request and result beat structs, the controller to datapath
// command and status structs, and the operation and status codes.
package sklt_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic [1:0] OP_INS  = 2'd0;
  localparam logic [1:0] OP_REM  = 2'd1;
  localparam logic [1:0] OP_LIST = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] entry_id;
    logic [15:0] sort_key;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [15:0] out_key;
    logic        has_entry;
    logic        last;
  } res_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic exec;
    logic list_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       list_done;
  } dp_stat_t;

endpackage

// ===== sv/sklt_dp.sv =====
// Datapath of the sorted keyed list table: request register, the row of
// entry cells with their parallel compares, and the result register.
// Depends on sklt_pkg.
module sklt_dp #(
  parameter int CAPACITY = sklt_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sklt_pkg::req_t       in_data,
  input  sklt_pkg::ctrl_cmd_t  cmd,
  output sklt_pkg::dp_stat_t   stat,
  output sklt_pkg::res_t       out_data
);
  import sklt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [1:0]          op_r;
  logic [15:0]         id_r;
  logic [15:0]         key_r;
  logic [15:0]         ids_r   [CAPACITY];
  logic [15:0]         ids_nxt [CAPACITY];
  logic [15:0]         keys_r  [CAPACITY];
  logic [15:0]         keys_nxt[CAPACITY];
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    lidx_r, lidx_nxt;
  logic [CNT_W-1:0]    cnt_m1;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [CAPACITY-1:0] ge_r, ge_nxt;
  logic [CAPACITY-1:0] ge_prev;
  logic [CAPACITY-1:0] rm_sh;
  logic                dup, full, empty, ins_ok, done;
  res_t                res_r, res_nxt;

  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign dup     = |match_r;
  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign ins_ok  = !dup && !full;
  assign done    = empty || (lidx_r == cnt_m1);
  assign ge_prev = ge_r << 1;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = (CNT_W'(i) < cnt_r) && (ids_r[i] == id_r);
      ge_nxt[i]    = (CNT_W'(i) < cnt_r) && (keys_r[i] >= key_r);
      rm_sh[i]     = |(match_r & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));
    end
  end

  always_comb begin
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    lidx_nxt = lidx_r;
    ids_nxt  = ids_r;
    keys_nxt = keys_r;
    if (cmd.compare) begin
      lidx_nxt = '0;
    end
    if (cmd.exec) begin
      res_nxt.out_id    = '0;
      res_nxt.out_key   = '0;
      res_nxt.has_entry = 1'b0;
      res_nxt.last      = 1'b1;
      case (op_r)
        OP_INS: begin
          if (dup) begin
            res_nxt.status = ST_DUP;
          end else if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            res_nxt.status = ST_OK;
          end
          if (ins_ok) begin
            cnt_nxt = cnt_r + CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              if (ge_prev[i]) begin
                ids_nxt[i]  = ids_r[(i == 0) ? 0 : i - 1];
                keys_nxt[i] = keys_r[(i == 0) ? 0 : i - 1];
              end else if (ge_r[i] || (CNT_W'(i) == cnt_r)) begin
                ids_nxt[i]  = id_r;
                keys_nxt[i] = key_r;
              end
            end
          end
        end
        OP_REM: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else if (dup) begin
            res_nxt.status = ST_OK;
          end else begin
            res_nxt.status = ST_NOTFOUND;
          end
          if (dup) begin
            cnt_nxt = cnt_m1;
            for (int i = 0; i < CAPACITY; i++) begin
              if (rm_sh[i]) begin
                ids_nxt[i]  = ids_r[(i == CAPACITY - 1) ? i : i + 1];
                keys_nxt[i] = keys_r[(i == CAPACITY - 1) ? i : i + 1];
              end
            end
          end
        end
        default: begin
          res_nxt.status = ST_OK;
        end
      endcase
    end
    if (cmd.list_step) begin
      if (empty) begin
        res_nxt.status    = ST_EMPTY;
        res_nxt.out_id    = '0;
        res_nxt.out_key   = '0;
        res_nxt.has_entry = 1'b0;
        res_nxt.last      = 1'b1;
      end else begin
        res_nxt.status    = ST_OK;
        res_nxt.out_id    = ids_r[0];
        res_nxt.out_key   = keys_r[0];
        res_nxt.has_entry = 1'b1;
        res_nxt.last      = done;
        for (int i = 0; i < CAPACITY; i++) begin
          if (CNT_W'(i) == cnt_m1) begin
            ids_nxt[i]  = ids_r[0];
            keys_nxt[i] = keys_r[0];
          end else if (CNT_W'(i) < cnt_m1) begin
            ids_nxt[i]  = ids_r[(i == CAPACITY - 1) ? i : i + 1];
            keys_nxt[i] = keys_r[(i == CAPACITY - 1) ? i : i + 1];
          end
        end
      end
      lidx_nxt = done ? '0 : lidx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lidx_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      lidx_r <= lidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      id_r  <= in_data.entry_id;
      key_r <= in_data.sort_key;
    end
    if (cmd.compare) begin
      match_r <= match_nxt;
      ge_r    <= ge_nxt;
    end
    ids_r  <= ids_nxt;
    keys_r <= keys_nxt;
    res_r  <= res_nxt;
  end

  assign stat.op        = op_r;
  assign stat.list_done = done;
  assign out_data       = res_r;

endmodule

// ===== sv/sklt_ctrl.sv =====
// Controller of the sorted keyed list table: sequences accept, compare,
// update and list steps, and owns both handshakes.
// Depends on sklt_pkg.
module sklt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sklt_pkg::dp_stat_t   stat,
  output sklt_pkg::ctrl_cmd_t  cmd
);
  import sklt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_LIST = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        case (stat.op)
          OP_INS, OP_REM: state_nxt = S_EXEC;
          OP_LIST:        state_nxt = S_LIST;
          default:        state_nxt = S_IDLE;
        endcase
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec = 1'b1;
          in_ready = 1'b1;
          cmd.load = in_valid;
          state_nxt = in_valid ? S_CMP : S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free) begin
          cmd.list_step = 1'b1;
          if (stat.list_done) begin
            in_ready  = 1'b1;
            cmd.load  = in_valid;
            state_nxt = in_valid ? S_CMP : S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ready) || cmd.exec || cmd.list_step;
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/sorted_keyed_list_table_unit.sv =====
// Sorted keyed list table: insert and remove run back to back while the output is
// free, each as a compare step across all cells and an update step that also loads
// the result. A list takes a compare step and then a list step per entry, set by the
// cell rotation, and a list of an empty table ends with its first list step.
// The result is registered in the update or list step once the output is free.
// Synchronous active-low reset empties the table; stored entries are not cleared.
module sorted_keyed_list_table_unit #(
  parameter int CAPACITY = sklt_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sklt_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sklt_pkg::res_t out_data
);
  import sklt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  sklt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sklt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== sv/sklt_checker.sv =====
// Port-level checks for the sorted keyed list table, bound to the top level.
// Depends on sklt_pkg.
module sklt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input sklt_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_ready,
  input sklt_pkg::res_t out_data
);
  import sklt_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request beat changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.has_entry |-> out_data.status == ST_OK)
    else $error("listed entry without ok status");

  a_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_entry |->
      out_data.out_id == '0 && out_data.out_key == '0 && out_data.last)
    else $error("status beat carries entry data or is not last");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted during compare");

endmodule

bind sorted_keyed_list_table_unit sklt_checker u_sklt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
